[design/assert_macros.svh]
// Assertion helpers for the checker file.
// Every macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SM4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sm4_pkg.sv]
`default_nettype none

package sm4_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_ROUND
  } sm4_state_t;

  // System parameter FK, which is XORed into the key before expansion.
  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  // SM4 S-box.
  localparam logic [7:0] SBOX [0:255] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Apply the S-box to each byte of a word.
  function automatic logic [31:0] sub_bytes(input logic [31:0] v);
    sub_bytes = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // CK word for round idx: byte j, most significant first, is 7 * (4 * idx + j) mod 256.
  function automatic logic [31:0] ck_word(input logic [7:0] idx);
    logic [7:0]  base;
    logic [31:0] w;
    base = {idx[5:0], 2'b00};
    w    = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    ck_word = w;
  endfunction

endpackage

`default_nettype wire

[design/sm4_rk_mem.sv]
`default_nettype none

module sm4_rk_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [31:0]   rd_data
);

  logic [31:0] mem_r [0:DEPTH-1];
  logic [31:0] rd_data_r;

  // Round key store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/sm4_round.sv]
`default_nettype none

module sm4_round
  import sm4_pkg::*;
(
  input  wire logic        key_mode,
  input  wire logic [31:0] mix_in,
  input  wire logic [31:0] base_in,
  output logic      [31:0] word_out
);

  logic [31:0] sub_w;
  logic [31:0] lin_w;

  // Nonlinear layer, shared by key expansion and data rounds.
  assign sub_w = sub_bytes(mix_in);

  // Key expansion uses the short linear map; data rounds use the full one.
  always_comb begin
    if (key_mode) begin
      lin_w = sub_w ^ {sub_w[18:0], sub_w[31:19]} ^ {sub_w[8:0], sub_w[31:9]};
    end else begin
      lin_w = sub_w ^ {sub_w[29:0], sub_w[31:30]} ^ {sub_w[21:0], sub_w[31:22]}
            ^ {sub_w[13:0], sub_w[31:14]} ^ {sub_w[7:0], sub_w[31:8]};
    end
  end

  assign word_out = base_in ^ lin_w;

endmodule

`default_nettype wire

[design/sm4_block_encrypt_core.sv]
`default_nettype none

// SM4 block encryption engine. Pulse start while busy is low to transfer one 128-bit plaintext
// block; busy stays high until the ciphertext is delivered. The result appears on the out_ ports
// for exactly one cycle with out_valid high and cannot be held off, so the receiver must take
// it then. A block first primes the round key memory read and then runs its rounds through a
// single shared round unit; out_valid rises in the same cycle in which busy goes low again. The
// first block after reset or after any key write first runs the key expansion, one round key
// written to the memory per cycle. Write key words only while busy is low.
module sm4_block_encrypt_core
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_plain_word_0,
  input  wire logic [31:0] in_plain_word_1,
  input  wire logic [31:0] in_plain_word_2,
  input  wire logic [31:0] in_plain_word_3,
  output logic             out_valid,
  output logic      [31:0] out_cipher_word_0,
  output logic      [31:0] out_cipher_word_1,
  output logic      [31:0] out_cipher_word_2,
  output logic      [31:0] out_cipher_word_3,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int              CW   = $clog2(ROUND_COUNT);
  localparam logic [CW-1:0]   LAST = CW'(ROUND_COUNT - 1);

  sm4_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          keys_ready_r;
  logic          out_valid_r;
  logic [31:0]   key_r [0:3];
  logic [31:0]   k_r   [0:3];
  logic [31:0]   x_r   [0:3];
  logic [31:0]   cipher_r [0:3];

  logic          last_w;
  logic          key_mode;
  logic          mem_we;
  logic [CW-1:0] mem_raddr;
  logic [31:0]   rk_rd;
  logic [31:0]   mix_w;
  logic [31:0]   base_w;
  logic [31:0]   new_word;

  assign last_w = (cnt_r == LAST);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = keys_ready_r ? ST_PREP : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (last_w) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP:  state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (last_w) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs decoded from the state.
  always_comb begin
    busy      = 1'b1;
    key_mode  = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = cnt_r + CW'(1);
    cnt_nxt   = '0;
    case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_EXPAND: begin
        key_mode = 1'b1;
        mem_we   = 1'b1;
        cnt_nxt  = last_w ? '0 : cnt_r + CW'(1);
      end
      ST_PREP:   mem_raddr = '0;
      ST_ROUND:  cnt_nxt = last_w ? '0 : cnt_r + CW'(1);
      default:   busy = 1'b1;
    endcase
  end

  // Round operand: key words with CK during expansion, data words with the stored key after.
  always_comb begin
    if (key_mode) begin
      mix_w  = k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(8'(cnt_r));
      base_w = k_r[0];
    end else begin
      mix_w  = x_r[1] ^ x_r[2] ^ x_r[3] ^ rk_rd;
      base_w = x_r[0];
    end
  end

  sm4_round u_round (
    .key_mode (key_mode),
    .mix_in   (mix_w),
    .base_in  (base_w),
    .word_out (new_word)
  );

  sm4_rk_mem #(
    .DEPTH (ROUND_COUNT),
    .AW    (CW)
  ) u_rk_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_r),
    .wr_data (new_word),
    .rd_addr (mem_raddr),
    .rd_data (rk_rd)
  );

  // Control registers and key configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_ROUND) && last_w;
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_wdata;
        keys_ready_r     <= 1'b0;
      end else if (state_r == ST_EXPAND && last_w) begin
        keys_ready_r <= 1'b1;
      end
    end
  end

  // Datapath: both word windows shift by one word per round.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_r[0] <= in_plain_word_0;
          x_r[1] <= in_plain_word_1;
          x_r[2] <= in_plain_word_2;
          x_r[3] <= in_plain_word_3;
          k_r[0] <= key_r[0] ^ FK0;
          k_r[1] <= key_r[1] ^ FK1;
          k_r[2] <= key_r[2] ^ FK2;
          k_r[3] <= key_r[3] ^ FK3;
        end
      end
      ST_EXPAND: begin
        k_r[0] <= k_r[1];
        k_r[1] <= k_r[2];
        k_r[2] <= k_r[3];
        k_r[3] <= new_word;
      end
      ST_ROUND: begin
        x_r[0] <= x_r[1];
        x_r[1] <= x_r[2];
        x_r[2] <= x_r[3];
        x_r[3] <= new_word;
        if (last_w) begin
          cipher_r[0] <= new_word;
          cipher_r[1] <= x_r[3];
          cipher_r[2] <= x_r[2];
          cipher_r[3] <= x_r[1];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_cipher_word_0 = cipher_r[0];
  assign out_cipher_word_1 = cipher_r[1];
  assign out_cipher_word_2 = cipher_r[2];
  assign out_cipher_word_3 = cipher_r[3];

endmodule

`default_nettype wire

[design/sm4_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module sm4_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // A transfer always starts work.
  `SM4_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted block did not raise busy")

  // The result strobe lasts a single cycle.
  `SM4_ASSERT_NXT(a_strobe_once, out_valid, !out_valid, "out_valid held for more than one cycle")

  // A result is delivered only once the engine has gone idle.
  `SM4_ASSERT_IMP(a_valid_idle, out_valid, !busy, "out_valid while busy")

  // Every end of work delivers a result.
  `SM4_ASSERT_IMP(a_fall_valid, $fell(busy) && $past(rst_n), out_valid,
                  "busy dropped without a result")

endmodule

bind sm4_block_encrypt_core sm4_checker u_sm4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

[verif/sm4_block_encrypt_core_tb.sv]
`timescale 1ns / 1ps

module sm4_block_encrypt_core_tb;
  import sm4_pkg::*;

  localparam int N_ROUNDS = 32;

  // Key register indexes of the configuration port.
  localparam logic [1:0] REG_KEY_WORD_0 = 2'd0;
  localparam logic [1:0] REG_KEY_WORD_3 = 2'd3;

  // Word i of a block sits at index [i].
  typedef logic [3:0][31:0] sm4_blk_t;

  localparam logic [31:0] FK_CONST [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX_LUT [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_plain_word_0 = '0;
  logic [31:0] in_plain_word_1 = '0;
  logic [31:0] in_plain_word_2 = '0;
  logic [31:0] in_plain_word_3 = '0;
  logic        out_valid;
  logic [31:0] out_cipher_word_0;
  logic [31:0] out_cipher_word_1;
  logic [31:0] out_cipher_word_2;
  logic [31:0] out_cipher_word_3;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Predictor state: key registers, expanded schedule and its valid flag.
  logic [31:0] key_model [4] = '{default: '0};
  logic [31:0] round_key_model [N_ROUNDS];
  logic        sched_valid = 1'b0;

  sm4_blk_t plain_pending_q [$];
  sm4_blk_t cipher_expect_q [$];
  sm4_blk_t cur_block = '0;
  logic     holding = 1'b0;
  int       gap_left = 0;
  logic     burst_mode = 1'b0;
  int       mismatch_count = 0;

  sm4_block_encrypt_core #(.ROUND_COUNT(N_ROUNDS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_plain_word_0  (in_plain_word_0),
    .in_plain_word_1  (in_plain_word_1),
    .in_plain_word_2  (in_plain_word_2),
    .in_plain_word_3  (in_plain_word_3),
    .out_valid        (out_valid),
    .out_cipher_word_0(out_cipher_word_0),
    .out_cipher_word_1(out_cipher_word_1),
    .out_cipher_word_2(out_cipher_word_2),
    .out_cipher_word_3(out_cipher_word_3),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Byte-wise S-box substitution.
  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX_LUT[v[31:24]], SBOX_LUT[v[23:16]], SBOX_LUT[v[15:8]], SBOX_LUT[v[7:0]]};
  endfunction

  // Encrypts one block, expanding the key first when the schedule is stale.
  function automatic sm4_blk_t encrypt_model(input sm4_blk_t pt);
    logic [31:0] k [4];
    logic [31:0] x [4];
    logic [31:0] t;
    sm4_blk_t    ct;
    if (!sched_valid) begin
      for (int i = 0; i < 4; i++) k[i] = key_model[i] ^ FK_CONST[i];
      for (int i = 0; i < N_ROUNDS; i++) begin
        t = {8'(28 * i), 8'(28 * i + 7), 8'(28 * i + 14), 8'(28 * i + 21)};
        t = tau(t ^ k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4]);
        t = t ^ rol32(t, 13) ^ rol32(t, 23);
        k[i % 4] = k[i % 4] ^ t;
        round_key_model[i] = k[i % 4];
      end
      sched_valid = 1'b1;
    end
    for (int i = 0; i < 4; i++) x[i] = pt[i];
    for (int i = 0; i < N_ROUNDS; i++) begin
      t = tau(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ round_key_model[i]);
      t = t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
      x[i % 4] = x[i % 4] ^ t;
    end
    for (int i = 0; i < 4; i++) ct[i] = x[3 - i];
    return ct;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Driver: presents pending blocks on start and predicts each accepted transfer.
  always @(posedge clk) begin
    int r;
    if (rst_n) begin
      if (start && !busy) begin
        cipher_expect_q.push_back(encrypt_model(cur_block));
        holding = 1'b0;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) gap_left = 0;
        else if (r < 85) gap_left = $urandom_range(1, 3);
        else if (r < 97) gap_left = $urandom_range(4, 15);
        else gap_left = $urandom_range(20, 60);
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (plain_pending_q.size() > 0) begin
          cur_block = plain_pending_q.pop_front();
          holding = 1'b1;
        end
      end
      start           <= holding;
      in_plain_word_0 <= cur_block[0];
      in_plain_word_1 <= cur_block[1];
      in_plain_word_2 <= cur_block[2];
      in_plain_word_3 <= cur_block[3];
    end
  end

  // Monitor: every strobed ciphertext is checked against the oldest prediction.
  always @(posedge clk) begin
    sm4_blk_t got;
    sm4_blk_t want;
    if (rst_n && out_valid) begin
      got = {out_cipher_word_3, out_cipher_word_2, out_cipher_word_1, out_cipher_word_0};
      if (cipher_expect_q.size() == 0) begin
        report_mismatch($sformatf("ciphertext %032h with no block outstanding", got));
      end else begin
        want = cipher_expect_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i])
            report_mismatch($sformatf("cipher_word_%0d: got %08h, expected %08h",
                                      i, got[i], want[i]));
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic queue_block(input logic [31:0] w0, w1, w2, w3);
    plain_pending_q.push_back({w3, w2, w1, w0});
  endtask

  // Returns at a falling edge once no transfer is pending or in flight.
  task automatic wait_idle();
    do @(negedge clk);
    while (plain_pending_q.size() != 0 || holding || start || cipher_expect_q.size() != 0 || busy);
  endtask

  // Writes the key words selected by mask once the engine is idle.
  task automatic load_key(input logic [3:0] mask, input sm4_blk_t key);
    wait_idle();
    if (mask != '0) begin
      for (int i = REG_KEY_WORD_0; i <= REG_KEY_WORD_3; i++) begin
        if (mask[i]) begin
          @(posedge clk);
          cfg_we    <= 1'b1;
          cfg_index <= 2'(i);
          cfg_wdata <= key[i];
          key_model[i] = key[i];
          sched_valid  = 1'b0;
        end
      end
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
    end
  endtask

  initial begin
    sm4_blk_t key_words;
    int       n;
    int       random_sent;
    random_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset key of all zeros, with the first block forcing the expansion.
    queue_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_block(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    queue_block(32'h8000_0000, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa);

    // Standard test key and plaintext.
    load_key(4'b1111, {32'h7654_3210, 32'hfedc_ba98, 32'h89ab_cdef, 32'h0123_4567});
    queue_block(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    queue_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_block($urandom, $urandom, $urandom, $urandom);

    // All-ones key.
    load_key(4'b1111, {4{32'hffff_ffff}});
    queue_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_block($urandom, $urandom, $urandom, $urandom);

    // Rewriting one word with its current value still forces a new expansion.
    load_key(4'b0100, {4{32'hffff_ffff}});
    queue_block(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    queue_block($urandom, $urandom, $urandom, $urandom);

    // Explicit all-zero key, blocks sent back to back.
    load_key(4'b1111, {4{32'h0000_0000}});
    burst_mode = 1'b1;
    queue_block(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
    queue_block(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
    queue_block($urandom, $urandom, $urandom, $urandom);

    // Random phases: partial, full or no rekeying between runs of random blocks.
    while (random_sent < 1100) begin
      for (int i = 0; i < 4; i++) key_words[i] = rand_word();
      load_key(4'($urandom_range(0, 15)), key_words);
      burst_mode = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 70);
      repeat (n) queue_block(rand_word(), rand_word(), rand_word(), rand_word());
      random_sent += n;
    end

    wait_idle();
    repeat (2 * N_ROUNDS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** sm4_block_encrypt_core: PASSED **");
    end else begin
      $display("** sm4_block_encrypt_core: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("** sm4_block_encrypt_core: FAILED **");
    $finish;
  end

endmodule

[sm4_block_encrypt_core.f]
+incdir+design
design/sm4_pkg.sv
design/sm4_rk_mem.sv
design/sm4_round.sv
design/sm4_block_encrypt_core.sv
design/sm4_checker.sv
verif/sm4_block_encrypt_core_tb.sv
